// ===== src/blas_pkg.sv =====
`default_nettype none
package blas_pkg;

    localparam int CordicSteps = 17;
    localparam int SqrtBits = 38;
    localparam int WideW = 76;
    localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
    localparam logic signed [15:0] PiQ13 = 16'sd25736;
    localparam logic [20:0] NearLimit = 21'd128;
    localparam logic [0:0] CfgSpeed = 1'b0;
    localparam logic [0:0] CfgGravity = 1'b1;

    typedef enum logic [1:0] {
        t_kind_normal = 2'd0,
        t_kind_vertical = 2'd1,
        t_kind_unreach = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic dx_neg;
        logic dy_pos;
    } t_ctl;

    function automatic logic signed [17:0] atan_q16(input logic [4:0] i);
        logic signed [17:0] v;
        begin
            case (i)
                5'd0: v = 18'sd51472;
                5'd1: v = 18'sd30386;
                5'd2: v = 18'sd16055;
                5'd3: v = 18'sd8150;
                5'd4: v = 18'sd4091;
                5'd5: v = 18'sd2047;
                5'd6: v = 18'sd1024;
                5'd7: v = 18'sd512;
                5'd8: v = 18'sd256;
                5'd9: v = 18'sd128;
                5'd10: v = 18'sd64;
                5'd11: v = 18'sd32;
                5'd12: v = 18'sd16;
                5'd13: v = 18'sd8;
                5'd14: v = 18'sd4;
                5'd15: v = 18'sd2;
                5'd16: v = 18'sd1;
                default: v = 18'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/blas_front.sv =====
`default_nettype none
module blas_front import blas_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire logic [19:0] i_source_x,
    input  wire logic [19:0] i_source_y,
    input  wire logic [19:0] i_target_x,
    input  wire logic [19:0] i_target_y,
    input  wire logic [15:0] i_speed,
    input  wire logic [15:0] i_gravity,
    output logic o_valid,
    output t_ctl o_ctl,
    output logic [WideW-1:0] o_disc,
    output logic [31:0] o_p,
    output logic [36:0] o_ga
);
    // Stage 1: differences, products.
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [20:0] r_dx, r_dy;
    logic [31:0] r_p1;
    logic [15:0] r_g1;
    logic signed [20:0] n_dx, n_dy;
    logic [20:0] w_a;
    logic [15:0] w_g;
    assign n_dx = $signed({i_target_x[19], i_target_x}) - $signed({i_source_x[19], i_source_x});
    assign n_dy = $signed({i_source_y[19], i_source_y}) - $signed({i_target_y[19], i_target_y});
    assign w_g = (i_gravity == 16'd0) ? 16'd1 : i_gravity;

    // Stage 2: A*A, P*P, D*P, G*A.
    logic [41:0] r_aa;
    logic [63:0] r_pp2;
    logic signed [53:0] r_dp;
    logic [36:0] r_ga2;
    logic [31:0] r_p2;
    logic [15:0] r_g2;
    t_ctl r_c2;
    assign w_a = r_dx[20] ? 21'(-r_dx) : 21'(r_dx);

    // Stage 3: q = G*A*A + 2*D*P.
    logic signed [59:0] r_q;
    logic [63:0] r_pp3;
    logic [36:0] r_ga3;
    logic [31:0] r_p3;
    logic [15:0] r_g3;
    t_ctl r_c3;

    // Stage 4: discriminant.
    logic [59:0] w_qm;
    logic [75:0] w_gq, w_pp;
    assign w_qm = r_q[59] ? 60'(-r_q) : 60'(r_q);
    assign w_gq = 76'(r_g3) * 76'(w_qm);
    assign w_pp = {12'd0, r_pp3};

    t_ctl w_c1;
    always_comb begin
        w_c1.dx_neg = r_dx[20];
        w_c1.dy_pos = !r_dy[20] && (r_dy != 21'sd0);
        w_c1.kind = (w_a < NearLimit) ? t_kind_vertical : t_kind_normal;
    end

    t_ctl w_c4;
    always_comb begin
        w_c4 = r_c3;
        if (!r_q[59] && w_gq > w_pp && r_c3.kind == t_kind_normal) w_c4.kind = t_kind_unreach;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_p1 <= 32'(i_speed) * 32'(i_speed);
            r_g1 <= w_g;
            r_aa <= 42'(w_a) * 42'(w_a);
            r_pp2 <= 64'(r_p1) * 64'(r_p1);
            r_dp <= 54'(r_dy) * $signed({22'd0, r_p1});
            r_ga2 <= 37'(r_g1) * 37'(w_a);
            r_p2 <= r_p1;
            r_g2 <= r_g1;
            r_c2 <= w_c1;
            r_q <= $signed(60'(r_g2) * 60'(r_aa)) + $signed({{5{r_dp[53]}}, r_dp, 1'b0});
            r_pp3 <= r_pp2;
            r_ga3 <= r_ga2;
            r_p3 <= r_p2;
            r_g3 <= r_g2;
            r_c3 <= r_c2;
            o_p <= r_p3;
            o_ga <= r_ga3;
            o_ctl <= w_c4;
            o_disc <= r_q[59] ? (w_pp + w_gq) : (w_pp - w_gq);
        end
    end
    assign o_valid = r_v4;
endmodule
`default_nettype wire

// ===== src/blas_sqrt.sv =====
`default_nettype none
module blas_sqrt import blas_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_ctl i_ctl,
    input  wire logic [WideW-1:0] i_disc,
    input  wire logic [31:0] i_p,
    input  wire logic [36:0] i_ga,
    output logic o_valid,
    output t_ctl o_ctl,
    output logic signed [47:0] o_y,
    output logic [36:0] o_ga
);
    // One result bit per stage, restoring square root in remainder form.
    logic r_v [SqrtBits+1];
    t_ctl r_c [SqrtBits+1];
    logic [WideW-1:0] r_rem [SqrtBits+1];
    logic [SqrtBits-1:0] r_root [SqrtBits+1];
    logic [31:0] r_p [SqrtBits+1];
    logic [36:0] r_ga [SqrtBits+1];

    always_comb begin
        r_v[0] = i_valid; r_c[0] = i_ctl; r_rem[0] = i_disc;
        r_root[0] = '0; r_p[0] = i_p; r_ga[0] = i_ga;
    end

    for (genvar k = 0; k < SqrtBits; k++) begin : g_st
        localparam int B = SqrtBits - 1 - k;
        logic [WideW+1:0] w_t;
        assign w_t = ({40'd0, r_root[k]} << (B + 1)) + (78'd1 << (2 * B));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else if (i_en) r_v[k+1] <= r_v[k];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c[k+1] <= r_c[k]; r_p[k+1] <= r_p[k]; r_ga[k+1] <= r_ga[k];
                if (w_t <= {2'b0, r_rem[k]}) begin
                    r_rem[k+1] <= r_rem[k] - w_t[WideW-1:0];
                    r_root[k+1] <= r_root[k] | (SqrtBits'(1) << B);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
            end
        end
    end

    assign o_valid = r_v[SqrtBits];
    assign o_ctl = r_c[SqrtBits];
    assign o_ga = r_ga[SqrtBits];
    assign o_y = $signed({16'd0, r_p[SqrtBits]}) - $signed({10'd0, r_root[SqrtBits]});
endmodule
`default_nettype wire

// ===== src/blas_cordic.sv =====
`default_nettype none
module blas_cordic import blas_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_ctl i_ctl,
    input  wire logic signed [47:0] i_y,
    input  wire logic [36:0] i_ga,
    output logic o_valid,
    output logic o_reachable,
    output logic signed [15:0] o_angle
);
    localparam int NS = 6;
    localparam int W = 50;
    // Normalization: doubling until one magnitude reaches 2^45, one shift group per stage.
    logic r_nv [NS+1];
    t_ctl r_nc [NS+1];
    logic signed [W-1:0] r_nx [NS+1];
    logic signed [W-1:0] r_ny [NS+1];
    always_comb begin
        r_nv[0] = i_valid; r_nc[0] = i_ctl;
        r_nx[0] = W'(i_ga); r_ny[0] = W'(i_y);
    end
    for (genvar k = 0; k < NS; k++) begin : g_n
        localparam int SH = 32 >> k;
        logic [W-1:0] w_ax, w_ay;
        logic w_ok;
        assign w_ax = r_nx[k][W-1] ? W'(-r_nx[k]) : W'(r_nx[k]);
        assign w_ay = r_ny[k][W-1] ? W'(-r_ny[k]) : W'(r_ny[k]);
        assign w_ok = ((w_ax << SH) < (W'(1) << 46)) && ((w_ay << SH) < (W'(1) << 46))
                      && (w_ax < (W'(1) << (46 - SH))) && (w_ay < (W'(1) << (46 - SH)));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_nv[k+1] <= 1'b0;
            else if (i_en) r_nv[k+1] <= r_nv[k];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nc[k+1] <= r_nc[k];
                r_nx[k+1] <= w_ok ? (r_nx[k] <<< SH) : r_nx[k];
                r_ny[k+1] <= w_ok ? (r_ny[k] <<< SH) : r_ny[k];
            end
        end
    end

    logic r_v [CordicSteps+1];
    t_ctl r_c [CordicSteps+1];
    logic signed [W-1:0] r_x [CordicSteps+1];
    logic signed [W-1:0] r_y [CordicSteps+1];
    logic signed [19:0] r_z [CordicSteps+1];
    always_comb begin
        r_v[0] = r_nv[NS]; r_c[0] = r_nc[NS];
        r_x[0] = r_nx[NS]; r_y[0] = r_ny[NS]; r_z[0] = '0;
    end
    for (genvar i = 0; i < CordicSteps; i++) begin : g_c
        logic signed [W-1:0] w_xs, w_ys;
        assign w_xs = r_x[i][W-1] ? -((-r_x[i]) >>> i) : (r_x[i] >>> i);
        assign w_ys = r_y[i][W-1] ? -((-r_y[i]) >>> i) : (r_y[i] >>> i);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else if (i_en) r_v[i+1] <= r_v[i];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c[i+1] <= r_c[i];
                if (!r_y[i][W-1] && r_y[i] != '0) begin
                    r_x[i+1] <= r_x[i] + w_ys; r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + 20'(atan_q16(5'(i)));
                end else begin
                    r_x[i+1] <= r_x[i] - w_ys; r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - 20'(atan_q16(5'(i)));
                end
            end
        end
    end

    logic signed [19:0] w_zr, w_th;
    logic signed [15:0] w_t, w_ang;
    t_ctl w_c;
    assign w_c = r_c[CordicSteps];
    assign w_zr = r_z[CordicSteps] + 20'sd4;
    assign w_th = w_zr >>> 3;
    assign w_t = 16'(w_th);
    always_comb begin
        case (w_c.kind)
            t_kind_vertical: w_ang = w_c.dy_pos ? -HalfPiQ13 : HalfPiQ13;
            t_kind_unreach: w_ang = 16'sd0;
            default: begin
                if (!w_c.dx_neg) w_ang = -w_t;
                else if (w_t > 16'sd0) w_ang = w_t - PiQ13;
                else w_ang = w_t + PiQ13;
            end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_v[CordicSteps];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_reachable <= (w_c.kind != t_kind_unreach);
            o_angle <= w_ang;
        end
    end
endmodule
`default_nettype wire

// ===== src/ballistic_launch_angle_solver.sv =====
// Launch angle solver for a flat projectile trajectory in y-down screen space.
// The slave stream carries one query per transaction: tdata holds source_x,
// source_y, target_x and target_y, 20 bits each, from the lowest bit up.
// The master stream returns one result per query: tdata holds reachable in
// bit 0 and fire_angle (signed Q3.13 radians) in bits 16:1.
// Launch speed (index 0) and gravity (index 1) are to be written through the
// config port only while the block is idle; the block itself does not enforce this.
// The pipeline accepts one transaction per cycle unless the receiver stalls while
// the output holds a result. Its stages are four front stages of products and the
// discriminant, 38 square root stages, six normalization stages, 17 CORDIC stages,
// one output stage and the final output register.
// A synchronous reset empties the pipeline and restores speed 9600 and
// gravity 6400. When the receiver stalls and the output holds a result,
// the whole pipeline holds; nothing is lost or repeated.
`default_nettype none
module ballistic_launch_angle_solver import blas_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input  wire logic [79:0] s_axis_tdata, // source_x, source_y, target_x, target_y
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    output logic [23:0] m_axis_tdata, // reachable, fire_angle, zero fill
    input  wire logic i_cfg_we,
    input  wire logic [0:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [15:0] r_speed, r_gravity;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= 16'd9600;
            r_gravity <= 16'd6400;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CfgSpeed) r_speed <= i_cfg_data;
            if (i_cfg_index == CfgGravity) r_gravity <= i_cfg_data;
        end
    end

    logic w_en, w_fv, w_sv, w_cv, w_reach;
    t_ctl w_fc, w_sc;
    logic [WideW-1:0] w_disc;
    logic [31:0] w_p;
    logic [36:0] w_ga, w_ga2;
    logic signed [47:0] w_y;
    logic signed [15:0] w_ang;
    logic r_ov, r_reach;
    logic [15:0] r_ang;

    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    blas_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_source_x(s_axis_tdata[19:0]), .i_source_y(s_axis_tdata[39:20]),
        .i_target_x(s_axis_tdata[59:40]), .i_target_y(s_axis_tdata[79:60]),
        .i_speed(r_speed), .i_gravity(r_gravity),
        .o_valid(w_fv), .o_ctl(w_fc), .o_disc(w_disc), .o_p(w_p), .o_ga(w_ga)
    );
    blas_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv), .i_ctl(w_fc),
        .i_disc(w_disc), .i_p(w_p), .i_ga(w_ga),
        .o_valid(w_sv), .o_ctl(w_sc), .o_y(w_y), .o_ga(w_ga2)
    );
    blas_cordic u_cordic (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_sv), .i_ctl(w_sc),
        .i_y(w_y), .i_ga(w_ga2),
        .o_valid(w_cv), .o_reachable(w_reach), .o_angle(w_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_cv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_reach <= w_reach;
            r_ang <= w_ang;
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {7'd0, r_ang, r_reach};
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import blas_pkg::*;

    typedef struct {
        logic signed [19:0] sx;
        logic signed [19:0] sy;
        logic signed [19:0] tx;
        logic signed [19:0] ty;
        bit has_known;
        bit known_reach;
        logic signed [15:0] known_angle;
    } t_query;

    typedef struct {
        bit reach;
        logic signed [15:0] angle;
    } t_solution;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata; // source_x, source_y, target_x, target_y
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata; // reachable, fire_angle, zero fill
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    logic [15:0] speed_reg;
    logic [15:0] gravity_reg;
    t_solution solutions_due[$];
    int errors;
    longint cycles;
    bit quiet_phase;
    int recv_count;
    int ready_hold;

    ballistic_launch_angle_solver DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [75:0] root_floor(input logic [75:0] v);
        logic [75:0] r;
        logic [75:0] c;
        begin
            r = '0;
            for (int b = 37; b >= 0; b--) begin
                c = r | (76'd1 << b);
                if (c * c <= v) r = c;
            end
            return r;
        end
    endfunction

    function automatic longint shift_toward_zero(input longint v, input int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        longint lim;
        begin
            z = 0;
            lim = 64'sd1 <<< 45;
            for (int i = 0; i < 64; i++) begin
                if ((x < 0 ? -x : x) >= lim || (y < 0 ? -y : y) >= lim) break;
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < CordicSteps; i++) begin
                xs = shift_toward_zero(x, i);
                ys = shift_toward_zero(y, i);
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + atan_q16(i[4:0]);
                end else begin
                    x = x - ys; y = y + xs; z = z - atan_q16(i[4:0]);
                end
            end
            return z;
        end
    endfunction

    function automatic t_solution solve_angle(input t_query q);
        t_solution res;
        longint dx;
        longint dy;
        longint a;
        longint g;
        longint p;
        longint qv;
        longint theta;
        longint v;
        logic signed [79:0] pp;
        logic signed [79:0] prod;
        logic signed [79:0] disc;
        logic [75:0] r;
        begin
            dx = longint'(q.tx) - longint'(q.sx);
            dy = longint'(q.sy) - longint'(q.ty);
            a = dx < 0 ? -dx : dx;
            g = gravity_reg == 0 ? 1 : longint'(gravity_reg);
            res.reach = 1'b1;
            if (a < 128) begin
                res.angle = dy > 0 ? -HalfPiQ13 : HalfPiQ13;
                return res;
            end
            p = longint'(speed_reg) * longint'(speed_reg);
            qv = g * a * a + 2 * dy * p;
            pp = 80'(p) * 80'(p);
            prod = 80'(g) * 80'(qv);
            disc = pp - prod;
            if (disc < 0) begin
                res.reach = 1'b0;
                res.angle = '0;
                return res;
            end
            r = root_floor(disc[75:0]);
            theta = vector_angle(g * a, p - longint'(r));
            v = theta + 4;
            theta = v >= 0 ? (v >>> 3) : -((-v + 7) >>> 3);
            if (dx >= 0) theta = -theta;
            else if (theta > 0) theta = theta - PiQ13;
            else theta = theta + PiQ13;
            res.angle = theta[15:0];
            return res;
        end
    endfunction

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= val;
            if (idx == CfgSpeed) speed_reg = val;
            else gravity_reg = val;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            while (solutions_due.size() != 0) @(posedge i_clk);
            repeat (80) @(posedge i_clk);
        end
    endtask

    task automatic send_query(input t_query q, input bit gaps);
        t_solution res;
        begin
            if (gaps && !quiet_phase && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            res = solve_angle(q);
            if (q.has_known && (res.reach != q.known_reach || res.angle != q.known_angle)) begin
                $display("%0t predictor: expected %0d/%0d, got %0d/%0d", $time,
                    q.known_reach, q.known_angle, res.reach, res.angle);
                errors++;
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {q.ty, q.tx, q.sy, q.sx};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            solutions_due.push_back(res);
        end
    endtask

    function automatic t_query random_query();
        t_query q;
        int mode;
        begin
            mode = $urandom_range(0, 9);
            q.has_known = 0;
            q.known_reach = 0;
            q.known_angle = 0;
            q.sx = 20'($urandom);
            q.sy = 20'($urandom);
            if (mode < 6) begin
                q.sx = 20'($urandom_range(0, 40000) - 20000);
                q.sy = 20'($urandom_range(0, 40000) - 20000);
                q.tx = q.sx + $signed(20'($urandom_range(0, 16000) - 8000));
                q.ty = q.sy + $signed(20'($urandom_range(0, 16000) - 8000));
            end else if (mode < 7) begin
                q.tx = q.sx + $signed(20'($urandom_range(0, 300) - 150));
                q.ty = 20'($urandom);
            end else begin
                q.tx = 20'($urandom);
                q.ty = 20'($urandom);
            end
            return q;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) m_axis_tready <= 1'b1;
        end else if (!quiet_phase && $urandom_range(0, 20) == 0) begin
            m_axis_tready <= 1'b0;
            ready_hold <= $urandom_range(1, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_solution want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (solutions_due.size() == 0) begin
                $display("%0t unexpected result: actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = solutions_due.pop_front();
                recv_count++;
                if (m_axis_tdata[0] != want.reach || m_axis_tdata[16:1] != want.angle) begin
                    $display("%0t mismatch: expected reach %0d angle %0d, actual reach %0d angle %0d",
                        $time, want.reach, want.angle, m_axis_tdata[0],
                        $signed(m_axis_tdata[16:1]));
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    t_query directed[$];

    function automatic t_query mk(input int sx, input int sy, input int tx, input int ty,
            input bit known, input bit reach, input int angle);
        t_query q;
        begin
            q.sx = 20'(sx); q.sy = 20'(sy); q.tx = 20'(tx); q.ty = 20'(ty);
            q.has_known = known; q.known_reach = reach; q.known_angle = 16'(angle);
            return q;
        end
    endfunction

    initial begin
        errors = 0;
        cycles = 0;
        recv_count = 0;
        quiet_phase = 0;
        speed_reg = 16'd9600;
        gravity_reg = 16'd6400;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(mk(0, 0, 0, 100, 1, 1, 12868));
        directed.push_back(mk(0, 100, 0, 0, 1, 1, -12868));
        directed.push_back(mk(0, 0, 127, 0, 1, 1, 12868));
        directed.push_back(mk(0, 0, -127, -5, 1, 1, -12868));
        directed.push_back(mk(0, 0, 128, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, -128, 0, 0, 0, 0));
        directed.push_back(mk(-524288, 0, 524287, 0, 1, 0, 0));
        directed.push_back(mk(524287, 524287, -524288, -524288, 1, 0, 0));
        directed.push_back(mk(0, -524288, 200, 524287, 0, 0, 0));
        directed.push_back(mk(0, 524287, 200, -524288, 0, 0, 0));
        directed.push_back(mk(1000, 2000, 5000, 1500, 0, 0, 0));
        directed.push_back(mk(1000, 2000, -3000, 2600, 0, 0, 0));
        directed.push_back(mk(0, 0, 400, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, -400, 0, 0, 0, 0));
        foreach (directed[i]) send_query(directed[i], 1);
        drain();

        write_reg(CfgSpeed, 16'd0);
        write_reg(CfgGravity, 16'd0);
        send_query(mk(0, 0, 500, 0, 1, 0, 0), 0);
        send_query(mk(0, 0, 5, 0, 1, 1, 12868), 0);
        drain();
        write_reg(CfgSpeed, 16'hFFFF);
        send_query(mk(0, 0, 128, 0, 0, 0, 0), 0);
        send_query(mk(0, 0, -128, 0, 0, 0, 0), 0);
        send_query(mk(0, 0, -524288, 524287, 0, 0, 0), 0);
        drain();
        write_reg(CfgGravity, 16'hFFFF);
        write_reg(CfgSpeed, 16'd1);
        send_query(mk(0, 0, 524287, 0, 1, 0, 0), 0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CfgSpeed, 16'd9600); write_reg(CfgGravity, 16'd6400); end
                1: begin write_reg(CfgSpeed, 16'hFFFF); write_reg(CfgGravity, 16'd1); end
                2: begin write_reg(CfgSpeed, 16'd3000); write_reg(CfgGravity, 16'hFFFF); end
                3: begin
                    write_reg(CfgSpeed, 16'($urandom_range(1, 65535)));
                    write_reg(CfgGravity, 16'($urandom_range(1, 65535)));
                end
                default: begin
                    quiet_phase = 1;
                    write_reg(CfgSpeed, 16'd9600);
                    write_reg(CfgGravity, 16'd6400);
                end
            endcase
            for (int n = 0; n < 110; n++) send_query(random_query(), 1);
            drain();
        end

        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/blas_pkg.sv
src/blas_front.sv
src/blas_sqrt.sv
src/blas_cordic.sv
src/ballistic_launch_angle_solver.sv
tb/testbench.sv
